[rtl/core/wlpd_pkg.sv]
// Shared types and constants for the windowed local peak detector.
`default_nettype none
package wlpd_pkg;

  localparam int SAMPLE_W        = 16;
  localparam int PIDX_W          = 17;
  localparam int WH_W            = 5;
  localparam int IN_TDATA_W      = 16;
  localparam int OUT_TDATA_W     = 24;
  localparam int DEF_MAX_HALF    = 16;
  localparam int DEF_MAX_SAMPLES = 65536;
  localparam logic [WH_W-1:0] WH_RESET = 5'd3;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_RESOLVE
  } state_t;

  typedef struct packed {
    logic shift;
    logic clear;
    logic clr_mark;
    logic new_cand;
    logic flush_all;
  } chain_ctrl_t;

  typedef struct packed {
    logic any_pending;
    logic peak_ok;
    logic head_valid;
    logic next_valid;
  } chain_stat_t;

endpackage
`default_nettype wire

[rtl/core/windowed_local_peak_detector.sv]
// Top level of the windowed local peak detector: control, counter, output stage.
// Candidates are checked one per cycle from the cycle after the beat, stalling while a
// found peak waits for the output; a peak is held and leaves with the check of the next
// peak of its beat or after the last check; the end marker follows the last peak or last
// check, or an empty beat. A new beat is taken only in idle, after the previous one is
// resolved. Reset (rst_n low, sync): state and flags cleared, window_half = 3.
`default_nettype none
module windowed_local_peak_detector #(
  parameter int MAX_HALF    = wlpd_pkg::DEF_MAX_HALF,
  parameter int MAX_SAMPLES = wlpd_pkg::DEF_MAX_SAMPLES
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_tvalid,
  output logic                                 in_tready,
  input  wire  [wlpd_pkg::IN_TDATA_W-1:0]      in_tdata,   // [15:0] sample
  input  wire                                  in_tlast,   // last
  output logic                                 out_tvalid,
  input  wire                                  out_tready,
  output logic [wlpd_pkg::OUT_TDATA_W-1:0]     out_tdata,  // [16:0] peak_index, [17] peak_found
  output logic                                 out_tlast,  // last_of_run
  input  wire                                  cfg_wr_en,
  input  wire  [wlpd_pkg::WH_W-1:0]            cfg_wr_data // window_half
);

  localparam int DEPTH = 2 * MAX_HALF + 1;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int PW    = wlpd_pkg::PIDX_W;

  wlpd_pkg::state_t       state_r, state_nxt;
  wlpd_pkg::chain_ctrl_t  ctrl;
  wlpd_pkg::chain_stat_t  stat;

  logic [wlpd_pkg::WH_W-1:0]            wh_cfg_r;
  logic [IDX_W-1:0]                     wh;
  logic [IDX_W-1:0]                     sel;
  logic signed [wlpd_pkg::SAMPLE_W-1:0] head_sample;
  logic signed [wlpd_pkg::SAMPLE_W-1:0] in_sample;

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic signed [1:0] slope_r, slope_nxt;
  logic              last_r, last_nxt;
  logic              hold_v_r, hold_v_nxt;
  logic [PW-1:0]     hold_idx_r, hold_idx_nxt;
  logic              out_v_r, out_v_nxt;
  logic [PW-1:0]     out_idx_r, out_idx_nxt;
  logic              out_found_r, out_found_nxt;
  logic              out_last_r, out_last_nxt;

  logic              accept;
  logic              emit_free;
  logic signed [wlpd_pkg::SAMPLE_W:0] diff;
  logic signed [1:0] slope_new;
  logic signed [2:0] slope_step;
  logic [PW-1:0]     peak_idx;

  assign in_sample = wlpd_pkg::SAMPLE_W'(in_tdata);
  assign wh = ({{(32-wlpd_pkg::WH_W){1'b0}}, wh_cfg_r} > 32'(MAX_HALF)) ?
              IDX_W'(MAX_HALF) : IDX_W'(wh_cfg_r);

  wlpd_chain #(.MAX_HALF(MAX_HALF), .DEPTH(DEPTH), .IDX_W(IDX_W)) u_chain (
    .clk(clk), .rst_n(rst_n), .ctrl(ctrl), .wh(wh), .in_sample(in_sample),
    .stat(stat), .sel(sel), .head_sample(head_sample)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wh_cfg_r <= wlpd_pkg::WH_RESET;
    end else if (cfg_wr_en) begin
      wh_cfg_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= wlpd_pkg::ST_IDLE;
      count_r  <= '0;
      slope_r  <= '0;
      last_r   <= 1'b0;
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      slope_r  <= slope_nxt;
      last_r   <= last_nxt;
      hold_v_r <= hold_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_idx_r  <= hold_idx_nxt;
    out_idx_r   <= out_idx_nxt;
    out_found_r <= out_found_nxt;
    out_last_r  <= out_last_nxt;
  end

  always_comb begin
    diff       = {in_sample[wlpd_pkg::SAMPLE_W-1], in_sample} -
                 {head_sample[wlpd_pkg::SAMPLE_W-1], head_sample};
    slope_new  = (diff > 0) ? 2'sd1 : ((diff < 0) ? -2'sd1 : 2'sd0);
    slope_step = {slope_new[1], slope_new} - {slope_r[1], slope_r};
    peak_idx   = (32'(count_r) > 32'(sel)) ? PW'(count_r - CNT_W'(sel)) : '0;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    slope_nxt     = slope_r;
    last_nxt      = last_r;
    hold_v_nxt    = hold_v_r;
    hold_idx_nxt  = hold_idx_r;
    out_v_nxt     = out_v_r && !out_tready;
    out_idx_nxt   = out_idx_r;
    out_found_nxt = out_found_r;
    out_last_nxt  = out_last_r;
    ctrl          = '0;
    ctrl.flush_all = last_r;
    emit_free     = !out_v_r || out_tready;
    in_tready     = 1'b0;
    accept        = 1'b0;

    unique case (state_r)
      wlpd_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        accept    = in_tvalid;
        if (accept) begin
          ctrl.shift    = 1'b1;
          ctrl.new_cand = stat.head_valid && stat.next_valid && slope_step[2];
          if (stat.head_valid) begin
            slope_nxt = slope_new;
          end
          if (count_r != CNT_W'(MAX_SAMPLES)) begin
            count_nxt = count_r + 1'b1;
          end
          last_nxt  = in_tlast;
          state_nxt = wlpd_pkg::ST_RESOLVE;
        end
      end
      wlpd_pkg::ST_RESOLVE: begin
        if (stat.any_pending) begin
          if (!(stat.peak_ok && hold_v_r && !emit_free)) begin
            ctrl.clr_mark = 1'b1;
            if (stat.peak_ok) begin
              if (hold_v_r) begin
                out_v_nxt     = 1'b1;
                out_idx_nxt   = hold_idx_r;
                out_found_nxt = 1'b1;
                out_last_nxt  = 1'b0;
              end
              hold_v_nxt   = 1'b1;
              hold_idx_nxt = peak_idx;
            end
          end
        end else if (hold_v_r) begin
          if (emit_free) begin
            out_v_nxt     = 1'b1;
            out_idx_nxt   = hold_idx_r;
            out_found_nxt = 1'b1;
            out_last_nxt  = !last_r;
            hold_v_nxt    = 1'b0;
            if (!last_r) begin
              state_nxt = wlpd_pkg::ST_IDLE;
            end
          end
        end else if (last_r) begin
          if (emit_free) begin
            out_v_nxt     = 1'b1;
            out_idx_nxt   = '0;
            out_found_nxt = 1'b0;
            out_last_nxt  = 1'b1;
            ctrl.clear    = 1'b1;
            count_nxt     = '0;
            slope_nxt     = '0;
            last_nxt      = 1'b0;
            state_nxt     = wlpd_pkg::ST_IDLE;
          end
        end else begin
          state_nxt = wlpd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = wlpd_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(wlpd_pkg::OUT_TDATA_W-PW-1){1'b0}}, out_found_r, out_idx_r};
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

[rtl/core/wlpd_cell.sv]
// One window cell: sample, valid and candidate mark, plus its window comparator.
`default_nettype none
module wlpd_cell #(
  parameter int POS   = 0,
  parameter int IDX_W = 6
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wlpd_pkg::chain_ctrl_t                ctrl,
  input  wire  [IDX_W-1:0]                     sel,
  input  wire  [IDX_W-1:0]                     wh,
  input  wire  signed [wlpd_pkg::SAMPLE_W-1:0] cand,
  input  wire  signed [wlpd_pkg::SAMPLE_W-1:0] prev_sample,
  input  wire                                  prev_valid,
  input  wire                                  prev_mark,
  output logic signed [wlpd_pkg::SAMPLE_W-1:0] sample,
  output logic                                 valid,
  output logic                                 mark,
  output logic                                 viol
);

  logic signed [wlpd_pkg::SAMPLE_W-1:0] sample_r;
  logic                                 valid_r;
  logic                                 mark_r;
  logic                                 in_range;
  logic [IDX_W:0]                       pos_x;
  logic [IDX_W:0]                       sel_x;
  logic [IDX_W:0]                       wh_x;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      mark_r  <= 1'b0;
    end else if (ctrl.clear) begin
      valid_r <= 1'b0;
      mark_r  <= 1'b0;
    end else if (ctrl.shift) begin
      valid_r <= prev_valid;
      mark_r  <= prev_mark;
    end else if (ctrl.clr_mark && (sel == IDX_W'(POS))) begin
      mark_r  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      sample_r <= prev_sample;
    end
  end

  always_comb begin
    pos_x    = (IDX_W+1)'(POS);
    sel_x    = {1'b0, sel};
    wh_x     = {1'b0, wh};
    in_range = (pos_x + wh_x >= sel_x) && (pos_x <= sel_x + wh_x);
  end

  assign sample = sample_r;
  assign valid  = valid_r;
  assign mark   = mark_r;
  assign viol   = valid_r && in_range && (sample_r > cand);

endmodule
`default_nettype wire

[rtl/core/wlpd_chain.sv]
// Shift chain of window cells with oldest-pending select and peak check.
`default_nettype none
module wlpd_chain #(
  parameter int MAX_HALF = wlpd_pkg::DEF_MAX_HALF,
  parameter int DEPTH    = 2 * MAX_HALF + 1,
  parameter int IDX_W    = $clog2(DEPTH)
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wlpd_pkg::chain_ctrl_t                ctrl,
  input  wire  [IDX_W-1:0]                     wh,
  input  wire  signed [wlpd_pkg::SAMPLE_W-1:0] in_sample,
  output wlpd_pkg::chain_stat_t                stat,
  output logic [IDX_W-1:0]                     sel,
  output logic signed [wlpd_pkg::SAMPLE_W-1:0] head_sample
);

  logic signed [wlpd_pkg::SAMPLE_W-1:0] sample_q [DEPTH];
  logic [DEPTH-1:0]                     valid_q;
  logic [DEPTH-1:0]                     mark_q;
  logic [DEPTH-1:0]                     viol_q;
  logic [DEPTH-1:0]                     pend;
  logic signed [wlpd_pkg::SAMPLE_W-1:0] cand;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    if (k == 0) begin : g_head
      wlpd_cell #(.POS(k), .IDX_W(IDX_W)) u_cell (
        .clk(clk), .rst_n(rst_n), .ctrl(ctrl), .sel(sel), .wh(wh), .cand(cand),
        .prev_sample(in_sample), .prev_valid(1'b1), .prev_mark(1'b0),
        .sample(sample_q[k]), .valid(valid_q[k]), .mark(mark_q[k]), .viol(viol_q[k])
      );
    end else if (k == 1) begin : g_next
      wlpd_cell #(.POS(k), .IDX_W(IDX_W)) u_cell (
        .clk(clk), .rst_n(rst_n), .ctrl(ctrl), .sel(sel), .wh(wh), .cand(cand),
        .prev_sample(sample_q[k-1]), .prev_valid(valid_q[k-1]),
        .prev_mark(ctrl.new_cand),
        .sample(sample_q[k]), .valid(valid_q[k]), .mark(mark_q[k]), .viol(viol_q[k])
      );
    end else begin : g_body
      wlpd_cell #(.POS(k), .IDX_W(IDX_W)) u_cell (
        .clk(clk), .rst_n(rst_n), .ctrl(ctrl), .sel(sel), .wh(wh), .cand(cand),
        .prev_sample(sample_q[k-1]), .prev_valid(valid_q[k-1]),
        .prev_mark(mark_q[k-1]),
        .sample(sample_q[k]), .valid(valid_q[k]), .mark(mark_q[k]), .viol(viol_q[k])
      );
    end
  end

  always_comb begin
    pend = '0;
    sel  = '0;
    for (int a = 1; a < DEPTH; a++) begin
      pend[a] = mark_q[a] && ((IDX_W'(a) >= wh) || ctrl.flush_all);
      if (pend[a]) begin
        sel = IDX_W'(a);
      end
    end
  end

  assign cand             = sample_q[sel];
  assign head_sample      = sample_q[0];
  assign stat.any_pending = |pend;
  assign stat.peak_ok     = ~|viol_q;
  assign stat.head_valid  = valid_q[0];
  assign stat.next_valid  = valid_q[1];

endmodule
`default_nettype wire

[rtl/core/wlpd_checker.sv]
// Port-level checks for the windowed local peak detector, bound to the top level.
`default_nettype none
module wlpd_checker (
  input wire                              clk,
  input wire                              rst_n,
  input wire                              in_tvalid,
  input wire                              in_tready,
  input wire                              out_tvalid,
  input wire                              out_tready,
  input wire [wlpd_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input wire                              out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result beat changed while stalled");

  a_marker_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[wlpd_pkg::PIDX_W] |->
      out_tlast && (out_tdata[wlpd_pkg::PIDX_W-1:0] == '0))
    else $error("end marker without tlast or with nonzero index");

  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input beat taken before previous one resolved");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[wlpd_pkg::OUT_TDATA_W-1:wlpd_pkg::PIDX_W+1] == '0))
    else $error("result padding bits not zero");

endmodule

bind windowed_local_peak_detector wlpd_checker u_wlpd_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_tvalid(in_tvalid),
  .in_tready(in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata(out_tdata),
  .out_tlast(out_tlast)
);
`default_nettype wire
